>>> design/assert_macros.svh
// Assertion helpers shared by the RTL. Reset is active low and synchronous.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SVU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SVU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/svu_pkg.sv
`timescale 1ns / 1ps

package svu_pkg;

  // Block length and field widths
  localparam int BLOCK_LEN = 16;
  localparam int SAMPLE_W  = 10;
  localparam int CNT_W     = 9;
  localparam int SUM_W     = 18;
  localparam int SQ_W      = 28;
  localparam int OUT_W     = 16;

  // Final computation widths
  localparam int SQR_W     = 2 * SUM_W;
  localparam int NUM_W     = SQ_W + CNT_W;
  localparam int SCALE     = 100;
  localparam int SCALE_W   = 7;
  localparam int P_W       = NUM_W + SCALE_W;
  localparam int DEN       = BLOCK_LEN * (BLOCK_LEN - 1);
  localparam int DEN_W     = $clog2(DEN + 1);

  // Scaled numerator at or above this gives a quotient beyond OUT_W bits
  localparam logic [P_W-1:0] SAT_LIMIT = P_W'(DEN) << OUT_W;

  // Division by DEN as a multiply by a rounded-up reciprocal. Below SAT_LIMIT the
  // dividend fits DIV_IN_W bits, and the shift is wide enough that the rounding
  // error never reaches the next integer.
  localparam int DIV_IN_W   = OUT_W + DEN_W;
  localparam int REC_SH     = OUT_W + 2 * DEN_W;
  localparam int REC_M_W    = REC_SH - DEN_W + 2;
  localparam int REC_PROD_W = DIV_IN_W + REC_M_W;
  localparam logic [REC_M_W-1:0] REC_M =
    REC_M_W'(((64'd1 << REC_SH) + 64'(DEN) - 64'd1) / 64'(DEN));

  // Block queue
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sumsq;
  } entry_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_SUB   = 7'b0000100,
    ST_SCALE = 7'b0001000,
    ST_CHECK = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } back_state_t;

endpackage

>>> design/sample_variance_unit_top.sv
`timescale 1ns / 1ps
// Sample variance unit: unbiased variance of blocks of BLOCK_LEN samples, times 100.
// Input channel in_valid / in_ready / in_sample: one 10-bit unsigned sample per transfer.
// Result channel out_valid / out_ready / out_variance_x100 / out_saturated: one
// transfer per completed block, giving floor(100*(N*sumsq - sum^2) / (N*(N-1)))
// clamped to 65535, with out_saturated high when the clamp applied.
// Throughput: one sample per cycle while the queue has room. The front accumulates each
// sample as it is taken and hands each finished block to a two-entry queue; the back
// works one block at a time (pop, products, subtract, scale, saturation check, one
// reciprocal multiply for the division by the constant N*(N-1), load), skipping the
// multiply when the result saturates. With N below 7 the queue can fill and in_ready
// drops until the back catches up.
// A finished block passes through the queue and the back's states before out_valid,
// and later if an earlier result still waits in the output register.
// Reset (rst_n low, synchronous) empties the queue, clears the count and both
// sums and drops out_valid. When the receiver stalls, the result holds in the
// output register, the back waits behind it, and in_ready falls once the queue
// has filled.

module sample_variance_unit_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [svu_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [svu_pkg::OUT_W-1:0]     out_variance_x100,
  output logic                          out_saturated
);

  // front to queue
  logic            push;
  svu_pkg::entry_t push_data;
  logic            fifo_full;
  // queue to back
  logic            fifo_valid;
  logic            fifo_pop;
  svu_pkg::entry_t fifo_data;

  // accumulate samples; drop the sums into the queue on the last one
  svu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // hold finished blocks so the front keeps taking samples
  svu_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .valid_o     (fifo_valid),
    .pop_i       (fifo_pop),
    .pop_data_o  (fifo_data)
  );

  // compute, divide and present the result
  svu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .fifo_valid_i      (fifo_valid),
    .fifo_data_i       (fifo_data),
    .fifo_pop_o        (fifo_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_variance_x100 (out_variance_x100),
    .out_saturated     (out_saturated)
  );

endmodule

>>> design/svu_front.sv
`timescale 1ns / 1ps

module svu_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [svu_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                          fifo_full_i,
  output logic                          push_o,
  output svu_pkg::entry_t               push_data_o
);

  logic [svu_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [svu_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [svu_pkg::SQ_W-1:0]       sumsq_r, sumsq_nxt;
  logic [2*svu_pkg::SAMPLE_W-1:0] square;
  logic [svu_pkg::SUM_W-1:0]      sum_add;
  logic [svu_pkg::SQ_W-1:0]       sumsq_add;
  logic                           accept;
  logic                           last;

  assign in_ready  = !fifo_full_i;
  assign accept    = in_valid && in_ready;
  assign square    = (2*svu_pkg::SAMPLE_W)'(in_sample) * (2*svu_pkg::SAMPLE_W)'(in_sample);
  assign sum_add   = sum_r + svu_pkg::SUM_W'(in_sample);
  assign sumsq_add = sumsq_r + svu_pkg::SQ_W'(square);
  assign last      = (count_r == svu_pkg::CNT_W'(svu_pkg::BLOCK_LEN - 1));

  // hand the finished block to the queue and clear
  assign push_o            = accept && last;
  assign push_data_o.sum   = sum_add;
  assign push_data_o.sumsq = sumsq_add;

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    if (accept) begin
      if (last) begin
        count_nxt = '0;
        sum_nxt   = '0;
        sumsq_nxt = '0;
      end else begin
        count_nxt = count_r + 1'b1;
        sum_nxt   = sum_add;
        sumsq_nxt = sumsq_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
    end
  end

endmodule

>>> design/svu_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module svu_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  svu_pkg::entry_t push_data_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output svu_pkg::entry_t pop_data_o
);

  svu_pkg::entry_t              mem [svu_pkg::FIFO_DEPTH];
  logic [svu_pkg::FIFO_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [svu_pkg::FIFO_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [svu_pkg::FIFO_AW:0]    count_r, count_nxt;

  assign full_o     = (count_r == (svu_pkg::FIFO_AW+1)'(svu_pkg::FIFO_DEPTH));
  assign valid_o    = (count_r != '0);
  assign pop_data_o = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_i  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (svu_pkg::FIFO_AW+1)'(push_i) - (svu_pkg::FIFO_AW+1)'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[wr_ptr_r] <= push_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `SVU_ASSERT_IMPL(a_no_overflow, clk, rst_n, push_i, !full_o, "push into a full block queue")
  `SVU_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop_i, valid_o, "pop from an empty block queue")

endmodule

>>> design/svu_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module svu_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fifo_valid_i,
  input  svu_pkg::entry_t              fifo_data_i,
  output logic                         fifo_pop_o,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [svu_pkg::OUT_W-1:0]    out_variance_x100,
  output logic                         out_saturated
);

  svu_pkg::back_state_t               state_r, state_nxt;
  svu_pkg::entry_t                    entry_r, entry_nxt;
  logic [svu_pkg::NUM_W-1:0]          nq_r, nq_nxt;
  logic [svu_pkg::SQR_W-1:0]          ss_r, ss_nxt;
  logic [svu_pkg::NUM_W-1:0]          num_r, num_nxt;
  logic [svu_pkg::P_W-1:0]            p_r, p_nxt;
  logic [svu_pkg::OUT_W-1:0]          quot_r, quot_nxt;
  logic                               sat_r, sat_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [svu_pkg::OUT_W-1:0]          out_var_r, out_var_nxt;
  logic                               out_sat_r, out_sat_nxt;
  logic [svu_pkg::REC_PROD_W-1:0]     recip_prod;
  logic                               load_out;

  assign recip_prod = svu_pkg::REC_PROD_W'(p_r[svu_pkg::DIV_IN_W-1:0]) *
                      svu_pkg::REC_PROD_W'(svu_pkg::REC_M);
  assign load_out   = (state_r == svu_pkg::ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt   = state_r;
    entry_nxt   = entry_r;
    nq_nxt      = nq_r;
    ss_nxt      = ss_r;
    num_nxt     = num_r;
    p_nxt       = p_r;
    quot_nxt    = quot_r;
    sat_nxt     = sat_r;
    fifo_pop_o  = 1'b0;
    unique case (state_r)
      svu_pkg::ST_IDLE: begin
        if (fifo_valid_i) begin
          fifo_pop_o = 1'b1;
          entry_nxt  = fifo_data_i;
          state_nxt  = svu_pkg::ST_MUL;
        end
      end
      svu_pkg::ST_MUL: begin
        nq_nxt    = svu_pkg::NUM_W'(entry_r.sumsq) * svu_pkg::NUM_W'(svu_pkg::BLOCK_LEN);
        ss_nxt    = svu_pkg::SQR_W'(entry_r.sum) * svu_pkg::SQR_W'(entry_r.sum);
        state_nxt = svu_pkg::ST_SUB;
      end
      svu_pkg::ST_SUB: begin
        // N*sumsq - sum^2 is never negative
        num_nxt   = nq_r - svu_pkg::NUM_W'(ss_r);
        state_nxt = svu_pkg::ST_SCALE;
      end
      svu_pkg::ST_SCALE: begin
        p_nxt     = svu_pkg::P_W'(num_r) * svu_pkg::P_W'(svu_pkg::SCALE);
        state_nxt = svu_pkg::ST_CHECK;
      end
      svu_pkg::ST_CHECK: begin
        if (p_r >= svu_pkg::SAT_LIMIT) begin
          quot_nxt  = '1;
          sat_nxt   = 1'b1;
          state_nxt = svu_pkg::ST_DONE;
        end else begin
          // below the limit the dividend fits the reciprocal multiplier
          sat_nxt   = 1'b0;
          state_nxt = svu_pkg::ST_DIV;
        end
      end
      svu_pkg::ST_DIV: begin
        quot_nxt  = recip_prod[svu_pkg::REC_SH +: svu_pkg::OUT_W];
        state_nxt = svu_pkg::ST_DONE;
      end
      svu_pkg::ST_DONE: begin
        if (load_out) begin
          state_nxt = svu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = svu_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = (out_valid_r && !out_ready) || load_out;
    out_var_nxt   = load_out ? quot_r : out_var_r;
    out_sat_nxt   = load_out ? sat_r  : out_sat_r;
  end

  assign out_valid         = out_valid_r;
  assign out_variance_x100 = out_var_r;
  assign out_saturated     = out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= svu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r   <= entry_nxt;
    nq_r      <= nq_nxt;
    ss_r      <= ss_nxt;
    num_r     <= num_nxt;
    p_r       <= p_nxt;
    quot_r    <= quot_nxt;
    sat_r     <= sat_nxt;
    out_var_r <= out_var_nxt;
    out_sat_r <= out_sat_nxt;
  end

  `SVU_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid_r && !out_ready, out_valid_r && $stable(out_var_r) && $stable(out_sat_r), "result changed while stalled")
  `SVU_ASSERT_IMPL(a_sat_clamps, clk, rst_n, out_valid_r && out_sat_r, out_var_r == '1, "saturated result not clamped")
  `SVU_ASSERT_NEXT(a_pop_starts_work, clk, rst_n, fifo_pop_o, state_r == svu_pkg::ST_MUL, "block popped without starting work")

endmodule

>>> tb/sample_variance_unit_top_tb.sv
`timescale 1ns / 1ps

module sample_variance_unit_top_tb;

  // Scale applied to the variance and the clamp value of the result
  localparam int unsigned PCT_SCALE   = 100;
  localparam int unsigned VAR_MAX     = 65535;
  // Random blocks after the directed table
  localparam int          RAND_BLOCKS = 24;
  // Receiver hold-off long enough to fill the queue and stall the input
  localparam int          HOLD_CYCLES = 400;
  // Drain allowance after the last expected result
  localparam int          TAIL_CYCLES = 60;
  localparam int          CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [svu_pkg::OUT_W-1:0] var_x100;
    logic                      sat;
  } var_result_t;

  // One directed row is one block of samples alternating between two values
  typedef struct packed {
    logic [svu_pkg::SAMPLE_W-1:0] even_smp;
    logic [svu_pkg::SAMPLE_W-1:0] odd_smp;
    logic                         typed;
    logic [svu_pkg::OUT_W-1:0]    exp_var;
    logic                         exp_sat;
  } blk_row_t;

  typedef struct packed {
    int          blk;
    var_result_t res;
  } typed_res_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [svu_pkg::SAMPLE_W-1:0] in_sample;
  logic                         out_valid;
  logic                         out_ready;
  logic [svu_pkg::OUT_W-1:0]    out_variance_x100;
  logic                         out_saturated;

  // Running block statistics mirrored from the accepted samples
  logic [svu_pkg::CNT_W-1:0]    acc_cnt;
  logic [svu_pkg::SUM_W-1:0]    acc_sum;
  logic [svu_pkg::SQ_W-1:0]     acc_sq;
  int                           blocks_done;

  var_result_t         variance_q[$];
  typed_res_t          typed_q[$];
  var_result_t         oldest;
  int                  err_cnt;
  int                  cycle_cnt;
  bit                  steady;
  bit                  hold_req;

  blk_row_t dir_tab [4] = '{
    // all zero straight after reset: no spread at all
    '{10'd0,    10'd0,    1'b1, 16'd0,     1'b0},
    // full scale throughout: still no spread
    '{10'd1023, 10'd1023, 1'b1, 16'd0,     1'b0},
    // rail to rail: far beyond the clamp
    '{10'd0,    10'd1023, 1'b1, 16'd65535, 1'b1},
    // one LSB of ripple: fractional mean, small truncated result
    '{10'd0,    10'd1,    1'b0, 16'd0,     1'b0}
  };

  sample_variance_unit_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_variance_x100 (out_variance_x100),
    .out_saturated     (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Fold one accepted sample into the block statistics; on the last sample of
  // a block work out the scaled variance and queue it.
  task automatic accumulate_sample(input logic [svu_pkg::SAMPLE_W-1:0] x);
    longint unsigned num;
    longint unsigned scaled;
    var_result_t     r;
    typed_res_t      tr;
    acc_sum = acc_sum + svu_pkg::SUM_W'(x);
    acc_sq  = acc_sq + svu_pkg::SQ_W'(x) * svu_pkg::SQ_W'(x);
    acc_cnt = acc_cnt + 1'b1;
    if (acc_cnt >= svu_pkg::CNT_W'(svu_pkg::BLOCK_LEN)) begin
      // exact mean: N*sumsq - sum^2 never goes negative
      num    = longint'(svu_pkg::BLOCK_LEN) * longint'(acc_sq) -
               longint'(acc_sum) * longint'(acc_sum);
      scaled = (longint'(PCT_SCALE) * num) /
               longint'(svu_pkg::BLOCK_LEN * (svu_pkg::BLOCK_LEN - 1));
      r.sat      = (scaled > longint'(VAR_MAX));
      r.var_x100 = r.sat ? svu_pkg::OUT_W'(VAR_MAX) : scaled[svu_pkg::OUT_W-1:0];
      // directed blocks with a typed-in answer are checked against that instead
      if (typed_q.size() != 0 && typed_q[0].blk == blocks_done) begin
        tr = typed_q.pop_front();
        r  = tr.res;
      end
      variance_q.push_back(r);
      blocks_done++;
      acc_cnt = '0;
      acc_sum = '0;
      acc_sq  = '0;
    end
  endtask

  // Gap before the next transfer: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady)   return 0;
    if (r < 45)   return 0;
    if (r < 85)   return $urandom_range(1, 3);
    if (r < 97)   return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one sample and hold it until the block takes it
  task automatic send_sample(input logic [svu_pkg::SAMPLE_W-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // Predict from every input transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      accumulate_sample(in_sample);
  end

  // Check every result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (variance_q.size() == 0) begin
        $error("unexpected result: variance_x100=%0d saturated=%0b",
               out_variance_x100, out_saturated);
        err_cnt++;
      end else begin
        oldest = variance_q.pop_front();
        if (out_variance_x100 !== oldest.var_x100) begin
          $error("variance_x100: expected %0d, actual %0d", oldest.var_x100, out_variance_x100);
          err_cnt++;
        end
        if (out_saturated !== oldest.sat) begin
          $error("saturated: expected %0b, actual %0b", oldest.sat, out_saturated);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: abandon a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** sample_variance_unit_top: FAILED **");
      $finish;
    end
  end

  // Receiver: random back-pressure, a clean stretch when steady, and one long
  // hold-off on request
  initial begin
    int k;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_req = 1'b0;
      end else if (steady || $urandom_range(0, 9) < 6) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(20, 60)) @(posedge clk);
        else
          repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  // Sender and run control
  initial begin
    int          b;
    int          i;
    int          mode;
    int          base;
    int          spread;
    int          val;
    logic [svu_pkg::SAMPLE_W-1:0] lo_smp;
    logic [svu_pkg::SAMPLE_W-1:0] hi_smp;
    typed_res_t  t;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_sample   = '0;
    acc_cnt     = '0;
    acc_sum     = '0;
    acc_sq      = '0;
    blocks_done = 0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    steady      = 1'b0;
    hold_req    = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register the typed-in answers before any block completes
    for (b = 0; b < 4; b++) begin
      if (dir_tab[b].typed) begin
        t.blk          = b;
        t.res.var_x100 = dir_tab[b].exp_var;
        t.res.sat      = dir_tab[b].exp_sat;
        typed_q.push_back(t);
      end
    end

    // Directed blocks
    for (b = 0; b < 4; b++)
      for (i = 0; i < svu_pkg::BLOCK_LEN; i++)
        send_sample(i[0] ? dir_tab[b].odd_smp : dir_tab[b].even_smp);

    // Random blocks, mostly narrow spreads so the result spans the clamp
    for (b = 0; b < RAND_BLOCKS; b++) begin
      // fill the queue while the receiver holds off
      if (b == 4) hold_req = 1'b1;
      steady = (b >= 4 && b < 8) || ($urandom_range(0, 5) == 0);
      // hold the sender until everything has drained
      if (b == 14) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (variance_q.size() != 0) @(posedge clk);
      end
      mode   = $urandom_range(0, 9);
      base   = $urandom_range(0, 1023);
      spread = $urandom_range(0, 90);
      lo_smp = svu_pkg::SAMPLE_W'($urandom_range(0, 1023));
      hi_smp = svu_pkg::SAMPLE_W'($urandom_range(0, 1023));
      for (i = 0; i < svu_pkg::BLOCK_LEN; i++) begin
        case (mode)
          6, 7: val = $urandom_range(0, 1023);
          8:    val = i[0] ? hi_smp : lo_smp;
          9:    val = base + $urandom_range(0, 2) - 1;
          default: val = base - spread / 2 + $urandom_range(0, spread);
        endcase
        if (val < 0)    val = 0;
        if (val > 1023) val = 1023;
        send_sample(svu_pkg::SAMPLE_W'(val));
      end
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    // Drain, then allow for any late or spurious result
    @(posedge clk);
    while (variance_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0 && variance_q.size() == 0)
      $display("** sample_variance_unit_top: PASSED **");
    else
      $display("** sample_variance_unit_top: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/svu_pkg.sv
design/svu_front.sv
design/svu_fifo.sv
design/svu_back.sv
design/sample_variance_unit_top.sv
tb/sample_variance_unit_top_tb.sv
